// ----- hdl/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// spg_pkg
// shared constants for the star pair geometry core: register map, field
// widths, fixed-point shifts and divider quotient length
// ----------------------------------------------------------------------------
package spg_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUAD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUAD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_NOISE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd3;

	localparam int QUAD_W      = 24;
	localparam int NOISE_W     = 16;
	localparam int SCALE_OUT_W = 49;
	localparam int TERM_W      = 32;

	localparam logic [NOISE_W-1:0] NOISE_RESET = 16'd256;

	// Q2.30 result from a Q33.16 divisor and Q17.8 numerator
	localparam int COS_SHIFT   = 38;
	localparam int NOISE_SHIFT = 16;

	// quotient bits kept by each divider: 32 result bits plus one overflow bit
	localparam int QUO_BITS = 33;

endpackage

// ----- hdl/star_pair_geometry_core.sv -----
// ----------------------------------------------------------------------------
// star_pair_geometry_core
// index check, triangular pair slot, squared separation with limit check,
// and code-frame and relative noise quotients for one star pair per cycle
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  input   | start / busy     | index_a index_b ax ay bx by
//  result  | done (strobe)    | index_ok pair_slot squared_scale scale_valid
//          |                  | cos_term sin_term rel_noise
//  config  | cfg_we           | cfg_index cfg_wdata
//
//  a word is taken every cycle that start is high; busy stays low
//  from accept to done a word passes five front stages (operands,
//  differences, squares, sum, limit check) then the 33-stage divider
//  pipelines, one quotient bit per stage, then the output register
//  the receiver cannot stall, so the pipeline advances every cycle
//  reset clears the valid chain and loads the register reset values
// ----------------------------------------------------------------------------
module star_pair_geometry_core #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [$clog2(MAX_POINTS)-1:0]     index_a,
	input  logic [$clog2(MAX_POINTS)-1:0]     index_b,
	input  logic [COORD_BITS-1:0]             ax,
	input  logic [COORD_BITS-1:0]             ay,
	input  logic [COORD_BITS-1:0]             bx,
	input  logic [COORD_BITS-1:0]             by,
	input  logic                              cfg_we,
	input  logic [spg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic                              done,
	output logic                              index_ok,
	output logic [2*$clog2(MAX_POINTS)-2:0]   pair_slot,
	output logic [spg_pkg::SCALE_OUT_W-1:0]   squared_scale,
	output logic                              scale_valid,
	output logic signed [spg_pkg::TERM_W-1:0] cos_term,
	output logic signed [spg_pkg::TERM_W-1:0] sin_term,
	output logic [spg_pkg::TERM_W-1:0]        rel_noise
);

	localparam int IW   = $clog2(MAX_POINTS);
	localparam int PW   = 2 * IW - 1;
	localparam int PCW  = $clog2(MAX_POINTS + 1);
	localparam int CB   = COORD_BITS;
	localparam int SW   = 2 * CB + 1;
	localparam int QW   = spg_pkg::QUAD_W;
	localparam int NZW  = spg_pkg::NOISE_W;
	localparam int SOW  = spg_pkg::SCALE_OUT_W;
	localparam int TW   = spg_pkg::TERM_W;
	localparam int QB   = spg_pkg::QUO_BITS;
	localparam int CMW  = (SW > 2 * QW) ? SW : 2 * QW;
	localparam int NWC  = CB + 1 + spg_pkg::COS_SHIFT;
	localparam int NWN  = 2 * NZW + spg_pkg::NOISE_SHIFT;
	localparam int LAT  = QB + 6;

	typedef struct packed {
		logic           iok;
		logic [PW-1:0]  pair;
		logic [SOW-1:0] scale;
		logic           sok;
		logic           neg_c;
		logic           neg_s;
	} side_t;

	// configuration
	logic [QW-1:0]  min_quad_size_q;
	logic [QW-1:0]  max_quad_size_q;
	logic [NZW-1:0] verify_noise_q;
	logic [PCW-1:0] point_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_quad_size_q <= '0;
			max_quad_size_q <= '0;
			verify_noise_q  <= spg_pkg::NOISE_RESET;
			point_count_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spg_pkg::CFG_MIN_QUAD:     min_quad_size_q <= cfg_wdata[QW-1:0];
				spg_pkg::CFG_MAX_QUAD:     max_quad_size_q <= cfg_wdata[QW-1:0];
				spg_pkg::CFG_VERIFY_NOISE: verify_noise_q  <= cfg_wdata[NZW-1:0];
				spg_pkg::CFG_POINT_COUNT:  point_count_q   <= cfg_wdata[PCW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic vld_s [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= QB; k++) vld_s[k] <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vld_s[0] <= v_s4;
			for (int k = 1; k <= QB; k++) vld_s[k] <= vld_s[k-1];
			done <= vld_s[QB];
		end
	end

	// stage 1: operands
	logic [IW-1:0] a_s1, b_s1;
	logic [CB-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	always_ff @(posedge clk) begin
		a_s1  <= index_a;
		b_s1  <= index_b;
		ax_s1 <= ax;
		ay_s1 <= ay;
		bx_s1 <= bx;
		by_s1 <= by;
	end

	// stage 2: differences, magnitudes, index check
	logic [CB:0]    dx, dy, ndx, ndy;
	logic [CB+1:0]  sc, sd, nsc, nsd;
	logic [PCW-1:0] lim;
	logic [2*IW-1:0] prod;
	logic           iok_c;

	assign dx  = {1'b0, bx_s1} - {1'b0, ax_s1};
	assign dy  = {1'b0, by_s1} - {1'b0, ay_s1};
	assign ndx = -dx;
	assign ndy = -dy;
	assign sc  = {dy[CB], dy} + {dx[CB], dx};
	assign sd  = {dy[CB], dy} - {dx[CB], dx};
	assign nsc = -sc;
	assign nsd = -sd;
	assign lim = (point_count_q > PCW'(MAX_POINTS)) ? PCW'(MAX_POINTS) : point_count_q;
	assign iok_c = (a_s1 < b_s1) && (PCW'(b_s1) < lim);
	assign prod  = (2*IW)'(b_s1) * (2*IW)'(b_s1 - 1'b1);

	logic [CB-1:0] mx_s2, my_s2;
	logic [CB:0]   mag_c_s2, mag_s_s2;
	logic          neg_c_s2, neg_s_s2, iok_s2;
	logic [PW-1:0] pair_s2;

	always_ff @(posedge clk) begin
		mx_s2    <= dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
		my_s2    <= dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
		neg_c_s2 <= sc[CB+1];
		neg_s_s2 <= sd[CB+1];
		mag_c_s2 <= sc[CB+1] ? nsc[CB:0] : sc[CB:0];
		mag_s_s2 <= sd[CB+1] ? nsd[CB:0] : sd[CB:0];
		iok_s2   <= iok_c;
		pair_s2  <= iok_c ? (prod[2*IW-1:1] + PW'(a_s1)) : '0;
	end

	// stage 3: squares
	logic [2*CB-1:0]  sx_s3, sy_s3;
	logic [2*QW-1:0]  min2_s3, max2_s3;
	logic [2*NZW-1:0] vn2_s3;
	logic             maxz_s3, neg_c_s3, neg_s_s3, iok_s3;
	logic [CB:0]      mag_c_s3, mag_s_s3;
	logic [PW-1:0]    pair_s3;

	always_ff @(posedge clk) begin
		sx_s3    <= (2*CB)'(mx_s2) * (2*CB)'(mx_s2);
		sy_s3    <= (2*CB)'(my_s2) * (2*CB)'(my_s2);
		min2_s3  <= (2*QW)'(min_quad_size_q) * (2*QW)'(min_quad_size_q);
		max2_s3  <= (2*QW)'(max_quad_size_q) * (2*QW)'(max_quad_size_q);
		vn2_s3   <= (2*NZW)'(verify_noise_q) * (2*NZW)'(verify_noise_q);
		maxz_s3  <= max_quad_size_q == '0;
		neg_c_s3 <= neg_c_s2;
		neg_s_s3 <= neg_s_s2;
		mag_c_s3 <= mag_c_s2;
		mag_s_s3 <= mag_s_s2;
		iok_s3   <= iok_s2;
		pair_s3  <= pair_s2;
	end

	// stage 4: squared separation
	logic [SW-1:0]    scale_s4;
	logic [2*QW-1:0]  min2_s4, max2_s4;
	logic [2*NZW-1:0] vn2_s4;
	logic             maxz_s4, neg_c_s4, neg_s_s4, iok_s4;
	logic [CB:0]      mag_c_s4, mag_s_s4;
	logic [PW-1:0]    pair_s4;

	always_ff @(posedge clk) begin
		scale_s4 <= SW'(sx_s3) + SW'(sy_s3);
		min2_s4  <= min2_s3;
		max2_s4  <= max2_s3;
		vn2_s4   <= vn2_s3;
		maxz_s4  <= maxz_s3;
		neg_c_s4 <= neg_c_s3;
		neg_s_s4 <= neg_s_s3;
		mag_c_s4 <= mag_c_s3;
		mag_s_s4 <= mag_s_s3;
		iok_s4   <= iok_s3;
		pair_s4  <= pair_s3;
	end

	// stage 5: limit check, then side data rides along with the dividers
	logic [SOW-1:0] scale_sat;

	if (SW > SOW) begin : g_sat
		assign scale_sat = (|scale_s4[SW-1:SOW]) ? '1 : scale_s4[SOW-1:0];
	end else begin : g_nosat
		assign scale_sat = SOW'(scale_s4);
	end

	side_t side_s [0:QB];

	always_ff @(posedge clk) begin
		side_s[0].iok   <= iok_s4;
		side_s[0].pair  <= pair_s4;
		side_s[0].scale <= scale_sat;
		side_s[0].sok   <= (scale_s4 != '0) && (CMW'(scale_s4) >= CMW'(min2_s4))
			&& (maxz_s4 || (CMW'(scale_s4) <= CMW'(max2_s4)));
		side_s[0].neg_c <= neg_c_s4;
		side_s[0].neg_s <= neg_s_s4;
		for (int k = 1; k <= QB; k++) side_s[k] <= side_s[k-1];
	end

	logic          sat_c, sat_s, sat_n;
	logic [QB-1:0] quo_c, quo_s, quo_n;

	spg_div #(.NW(NWC), .DW(SW), .QB(QB)) u_div_cos (
		.clk (clk),
		.num ({mag_c_s4, {spg_pkg::COS_SHIFT{1'b0}}}),
		.den (scale_s4),
		.sat (sat_c),
		.quo (quo_c)
	);

	spg_div #(.NW(NWC), .DW(SW), .QB(QB)) u_div_sin (
		.clk (clk),
		.num ({mag_s_s4, {spg_pkg::COS_SHIFT{1'b0}}}),
		.den (scale_s4),
		.sat (sat_s),
		.quo (quo_s)
	);

	spg_div #(.NW(NWN), .DW(SW), .QB(QB)) u_div_noise (
		.clk (clk),
		.num ({vn2_s4, {spg_pkg::NOISE_SHIFT{1'b0}}}),
		.den (scale_s4),
		.sat (sat_n),
		.quo (quo_n)
	);

	// signed saturation: positive caps at max, negative magnitude caps at 2^31
	function automatic logic [TW-1:0] term_sat(input logic neg, input logic ovf,
		input logic [QB-1:0] q);
		logic [TW-1:0] res;
		if (!neg) begin
			res = (ovf || q[QB-1:TW-1] != '0) ? {1'b0, {(TW-1){1'b1}}} : q[TW-1:0];
		end else if (ovf || q > {2'b01, {(TW-1){1'b0}}}) begin
			res = {1'b1, {(TW-1){1'b0}}};
		end else begin
			res = -q[TW-1:0];
		end
		return res;
	endfunction

	side_t sd_out;
	assign sd_out = side_s[QB];

	always_ff @(posedge clk) begin
		index_ok      <= sd_out.iok;
		pair_slot     <= sd_out.pair;
		squared_scale <= sd_out.scale;
		scale_valid   <= sd_out.sok;
		cos_term      <= sd_out.sok ? term_sat(sd_out.neg_c, sat_c, quo_c) : '0;
		sin_term      <= sd_out.sok ? term_sat(sd_out.neg_s, sat_s, quo_s) : '0;
		rel_noise     <= !sd_out.sok ? '0 : (sat_n || quo_n[QB-1]) ? '1 : quo_n[TW-1:0];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result strobe missing after accepted word");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !scale_valid |-> cos_term == '0 && sin_term == '0 && rel_noise == '0)
		else $error("quotients not cleared for rejected pair");

	a_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !index_ok |-> pair_slot == '0)
		else $error("pair slot set for bad indices");

	a_scale_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done && scale_valid |-> squared_scale != '0)
		else $error("zero separation passed limit check");

endmodule

// ----- hdl/spg_div.sv -----
// ----------------------------------------------------------------------------
// spg_div
// pipelined restoring divider, one quotient bit per stage, one word per
// cycle; flags when the quotient does not fit in QB bits
// ----------------------------------------------------------------------------
module spg_div #(
	parameter int NW = 63,
	parameter int DW = 49,
	parameter int QB = spg_pkg::QUO_BITS
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          sat,
	output logic [QB-1:0] quo
);

	localparam int HW = NW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [DW-1:0] rem_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [QB-1:0] lo_s  [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic          sat_s [0:QB];

	logic [HW-1:0] num_hi;
	assign num_hi = num[NW-1:QB];

	always_ff @(posedge clk) begin
		sat_s[0] <= CW'(num_hi) >= CW'(den);
		rem_s[0] <= DW'(num_hi);
		den_s[0] <= den;
		lo_s[0]  <= num[QB-1:0];
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;
		assign trial = {rem_s[k], lo_s[k][QB-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			den_s[k+1] <= den_s[k];
			lo_s[k+1]  <= {lo_s[k][QB-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
			sat_s[k+1] <= sat_s[k];
		end
	end

	assign sat = sat_s[QB];
	assign quo = quo_s[QB];

endmodule
